FILE: hdl/shp_pkg.sv
`default_nettype none

package shp_pkg;

    localparam logic [7:0]  SYNC_C        = 8'h43;
    localparam logic [7:0]  SYNC_P        = 8'h50;
    localparam logic [7:0]  SYNC_NUL      = 8'h00;
    localparam logic [9:0]  SYNC_BYTES    = 10'd4;
    localparam logic [9:0]  HEADER_BYTES  = 10'd8;
    localparam logic [9:0]  PAYLOAD_START = SYNC_BYTES + HEADER_BYTES;
    localparam logic [15:0] MAX_PAYLOAD   = 16'd512;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_LENGTH_OFFSET    = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LENGTH_MSB_FIRST = 1'd1;

    localparam int M_TDATA_W = 40;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_P1,
        PH_P2,
        PH_NUL,
        PH_HEADER,
        PH_DATA,
        PH_CHECK
    } shp_phase_t;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic [9:0]  byte_position;
        logic        frame_end;
        logic        frame_valid;
        logic [15:0] payload_length;
    } shp_result_t;

endpackage

`default_nettype wire

FILE: hdl/shp_in_stage.sv
`default_nettype none

module shp_in_stage (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,
    input  wire        take,
    output logic       in_valid,
    output logic [7:0] in_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

`default_nettype wire

FILE: hdl/shp_parse.sv
`default_nettype none

module shp_parse (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_wr_en,
    input  wire  [shp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire  [shp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire                                take,
    input  wire  [7:0]                         in_byte,
    output shp_pkg::shp_result_t               result
);

    shp_pkg::shp_phase_t phase_reg;
    shp_pkg::shp_phase_t phase_next;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic [9:0]  cnt_reg;
    logic [9:0]  cnt_next;
    logic [15:0] len_reg;
    logic [15:0] len_next;
    logic [2:0]  len_off_reg;
    logic        len_msb_reg;

    logic [7:0]  sum_add;
    logic [9:0]  cnt_inc;
    logic        hdr_last;
    logic [15:0] len_cap;
    logic        hit_first;
    logic        hit_second;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_off_reg <= '0;
            len_msb_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                shp_pkg::CFG_LENGTH_OFFSET: begin
                    len_off_reg <= cfg_wdata[2:0];
                end
                shp_pkg::CFG_LENGTH_MSB_FIRST: begin
                    len_msb_reg <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign sum_add    = sum_reg + in_byte;
    assign cnt_inc    = cnt_reg + 10'd1;
    assign hdr_last   = cnt_inc >= shp_pkg::HEADER_BYTES;
    assign hit_first  = cnt_reg == {7'd0, len_off_reg};
    assign hit_second = cnt_reg == {6'd0, {1'b0, len_off_reg} + 4'd1};

    always_comb begin
        len_cap = len_reg;
        if (hit_first) begin
            if (len_msb_reg) begin
                len_cap = {in_byte, len_reg[7:0]};
            end else begin
                len_cap = {len_reg[15:8], in_byte};
            end
        end else if (hit_second) begin
            if (len_msb_reg) begin
                len_cap = {len_reg[15:8], in_byte};
            end else begin
                len_cap = {in_byte, len_reg[7:0]};
            end
        end
    end

    always_comb begin
        case (phase_reg)
            shp_pkg::PH_HUNT: begin
                phase_next = (in_byte == shp_pkg::SYNC_C) ? shp_pkg::PH_P1 : shp_pkg::PH_HUNT;
            end
            shp_pkg::PH_P1: begin
                phase_next = (in_byte == shp_pkg::SYNC_P) ? shp_pkg::PH_P2 : shp_pkg::PH_HUNT;
            end
            shp_pkg::PH_P2: begin
                phase_next = (in_byte == shp_pkg::SYNC_P) ? shp_pkg::PH_NUL : shp_pkg::PH_HUNT;
            end
            shp_pkg::PH_NUL: begin
                phase_next = (in_byte == shp_pkg::SYNC_NUL) ? shp_pkg::PH_HEADER
                                                             : shp_pkg::PH_HUNT;
            end
            shp_pkg::PH_HEADER: begin
                if (!hdr_last) begin
                    phase_next = shp_pkg::PH_HEADER;
                end else if (len_cap > shp_pkg::MAX_PAYLOAD) begin
                    phase_next = shp_pkg::PH_HUNT;
                end else if (len_cap == 16'd0) begin
                    phase_next = shp_pkg::PH_CHECK;
                end else begin
                    phase_next = shp_pkg::PH_DATA;
                end
            end
            shp_pkg::PH_DATA: begin
                phase_next = ({6'd0, cnt_inc} >= len_reg) ? shp_pkg::PH_CHECK
                                                          : shp_pkg::PH_DATA;
            end
            shp_pkg::PH_CHECK: begin
                phase_next = shp_pkg::PH_HUNT;
            end
            default: begin
                phase_next = shp_pkg::PH_HUNT;
            end
        endcase
    end

    always_comb begin
        sum_next              = sum_reg;
        cnt_next              = cnt_reg;
        len_next              = len_reg;
        result.byte_value     = in_byte;
        result.byte_position  = 10'd0;
        result.frame_end      = 1'b0;
        result.frame_valid    = 1'b0;
        case (phase_reg)
            shp_pkg::PH_HUNT: begin
                sum_next = in_byte;
            end
            shp_pkg::PH_P1: begin
                sum_next             = sum_add;
                result.byte_position = 10'd1;
            end
            shp_pkg::PH_P2: begin
                sum_next             = sum_add;
                result.byte_position = 10'd2;
            end
            shp_pkg::PH_NUL: begin
                sum_next             = sum_add;
                cnt_next             = 10'd0;
                result.byte_position = 10'd3;
                if (in_byte == shp_pkg::SYNC_NUL) begin
                    len_next = 16'd0;
                end
            end
            shp_pkg::PH_HEADER: begin
                sum_next             = sum_add;
                len_next             = len_cap;
                cnt_next             = hdr_last ? 10'd0 : cnt_inc;
                result.byte_position = shp_pkg::SYNC_BYTES + cnt_reg;
            end
            shp_pkg::PH_DATA: begin
                sum_next             = sum_add;
                cnt_next             = cnt_inc;
                result.byte_position = shp_pkg::PAYLOAD_START + cnt_reg;
            end
            shp_pkg::PH_CHECK: begin
                result.byte_position = shp_pkg::PAYLOAD_START + len_reg[9:0];
                result.frame_end     = 1'b1;
                result.frame_valid   = sum_add == 8'd0;
            end
            default: begin
            end
        endcase
        result.payload_length = len_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= shp_pkg::PH_HUNT;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            len_reg   <= '0;
        end else if (take) begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/shp_out_stage.sv
`default_nettype none

module shp_out_stage (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                in_valid,
    input  wire  shp_pkg::shp_result_t         result,
    output logic                               out_ready,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [shp_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tlast,
    output logic                               m_tuser
);

    logic                 valid_reg;
    logic                 valid_next;
    shp_pkg::shp_result_t result_reg;

    assign out_ready  = !valid_reg || m_tready;
    assign valid_next = in_valid || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && out_ready) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, result_reg.payload_length, result_reg.byte_position,
                       result_reg.byte_value};
    assign m_tlast  = result_reg.frame_end;
    assign m_tuser  = result_reg.frame_valid;

endmodule

`default_nettype wire

FILE: hdl/sync_header_frame_parser.sv
// An input transfer passes the input register, parse logic and result register to the m_ side.
// Throughput: one byte per cycle while m_tready does not stall the result register.
// Each byte gives exactly one result transfer.
// Reset (aresetn low, synchronous): both stages empty, parser hunting for sync,
// sum, counter, captured length and config registers cleared.
`default_nettype none

module sync_header_frame_parser (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_wr_en,
    input  wire  [shp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire  [shp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [7:0]                         s_tdata,   // data_byte
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // byte_value[7:0], byte_position[17:8], payload_length[33:18], zero pad
    output logic [shp_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tlast,   // frame_end
    output logic                               m_tuser    // frame_valid
);

    logic                 in_valid;
    logic [7:0]           in_byte;
    logic                 out_ready;
    logic                 take;
    shp_pkg::shp_result_t result;

    assign take = in_valid && out_ready;

    shp_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (take),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    shp_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .take      (take),
        .in_byte   (in_byte),
        .result    (result)
    );

    shp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .result    (result),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

FILE: bench/frame_parse_checker.sv
`timescale 1ns / 100ps

module frame_parse_checker
    import shp_pkg::*;
(
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   cfg_wr_en,
    input  wire [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire                   s_tvalid,
    input  wire                   s_tready,
    input  wire [7:0]             s_tdata,
    input  wire                   m_tvalid,
    input  wire                   m_tready,
    input  wire [M_TDATA_W-1:0]   m_tdata,
    input  wire                   m_tlast,
    input  wire                   m_tuser,
    output int                    mismatch_count,
    output int                    outstanding
);

    localparam int PAD_LO = 34;

    shp_phase_t  ph;
    logic [7:0]  fsum;
    logic [9:0]  cnt;
    logic [15:0] plen;
    logic [2:0]  len_off;
    logic        len_msb;

    shp_result_t parsed_q [$];
    int          errs = 0;

    assign mismatch_count = errs;

    function automatic void flag(input string what);
        errs++;
        if (errs <= 10)
            $display("%0t: %s", $time, what);
    endfunction

    function automatic shp_result_t parse_byte(input logic [7:0] b);
        shp_result_t r;
        r = '0;
        r.byte_value = b;
        case (ph)
            PH_HUNT: begin
                fsum = b;
                if (b == SYNC_C)
                    ph = PH_P1;
            end
            PH_P1: begin
                r.byte_position = 10'd1;
                fsum += b;
                ph = (b == SYNC_P) ? PH_P2 : PH_HUNT;
            end
            PH_P2: begin
                r.byte_position = 10'd2;
                fsum += b;
                ph = (b == SYNC_P) ? PH_NUL : PH_HUNT;
            end
            PH_NUL: begin
                r.byte_position = 10'd3;
                fsum += b;
                cnt = '0;
                if (b == SYNC_NUL) begin
                    ph = PH_HEADER;
                    plen = '0;
                end else begin
                    ph = PH_HUNT;
                end
            end
            PH_HEADER: begin
                r.byte_position = SYNC_BYTES + cnt;
                fsum += b;
                if (cnt == {7'd0, len_off}) begin
                    if (len_msb)
                        plen[15:8] = b;
                    else
                        plen[7:0] = b;
                end else if (cnt == {7'd0, len_off} + 10'd1) begin
                    if (len_msb)
                        plen[7:0] = b;
                    else
                        plen[15:8] = b;
                end
                cnt++;
                if (cnt >= HEADER_BYTES) begin
                    cnt = '0;
                    if (plen > MAX_PAYLOAD)
                        ph = PH_HUNT;
                    else if (plen == 16'd0)
                        ph = PH_CHECK;
                    else
                        ph = PH_DATA;
                end
            end
            PH_DATA: begin
                r.byte_position = PAYLOAD_START + cnt;
                fsum += b;
                cnt++;
                if ({6'd0, cnt} >= plen)
                    ph = PH_CHECK;
            end
            PH_CHECK: begin
                r.byte_position = PAYLOAD_START + plen[9:0];
                r.frame_end = 1'b1;
                r.frame_valid = (8'(fsum + b) == 8'd0);
                ph = PH_HUNT;
            end
            default: begin
                ph = PH_HUNT;
            end
        endcase
        r.payload_length = plen;
        return r;
    endfunction

    always @(posedge aclk) begin : track
        shp_result_t want, got;
        if (!aresetn) begin
            ph = PH_HUNT;
            fsum = '0;
            cnt = '0;
            plen = '0;
            len_off = '0;
            len_msb = 1'b0;
            parsed_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_LENGTH_OFFSET:    len_off = cfg_wdata[2:0];
                    CFG_LENGTH_MSB_FIRST: len_msb = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.byte_value = m_tdata[7:0];
                got.byte_position = m_tdata[17:8];
                got.payload_length = m_tdata[33:18];
                got.frame_end = m_tlast;
                got.frame_valid = m_tuser;
                if (parsed_q.size() == 0) begin
                    flag($sformatf("unexpected transfer: val=%02h pos=%0d end=%0b ok=%0b len=%0d",
                        got.byte_value, got.byte_position, got.frame_end,
                        got.frame_valid, got.payload_length));
                end else begin
                    want = parsed_q.pop_front();
                    if (got !== want || m_tdata[M_TDATA_W-1:PAD_LO] !== '0)
                        flag($sformatf({"mismatch: exp val=%02h pos=%0d end=%0b ok=%0b len=%0d",
                            " | got val=%02h pos=%0d end=%0b ok=%0b len=%0d pad=%0h"},
                            want.byte_value, want.byte_position, want.frame_end,
                            want.frame_valid, want.payload_length,
                            got.byte_value, got.byte_position, got.frame_end,
                            got.frame_valid, got.payload_length,
                            m_tdata[M_TDATA_W-1:PAD_LO]));
                end
            end
            if (s_tvalid && s_tready)
                parsed_q.push_back(parse_byte(s_tdata));
        end
        outstanding <= parsed_q.size();
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import shp_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int ITEM_TARGET = 1400;
    localparam int PHASES      = 8;
    localparam int HDR_N       = int'(HEADER_BYTES);

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    int         mismatch_count;
    int         outstanding;
    int         sent_items = 0;
    int         s_idle_pct = 20;
    bit         tail = 1'b0;
    logic [2:0] cur_off = 3'd0;
    logic       cur_msb = 1'b0;

    always #5 aclk = ~aclk;

    sync_header_frame_parser uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    frame_parse_checker parse_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (!tail && $urandom_range(0, 99) < s_idle_pct) ? $urandom_range(1, 14) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        sent_items++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic set_parser(input logic [2:0] off, input logic msb);
        wait_drained();
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= CFG_LENGTH_OFFSET;
        cfg_wdata <= off;
        @(posedge aclk);
        cfg_addr <= CFG_LENGTH_MSB_FIRST;
        cfg_wdata <= {2'($urandom_range(0, 3)), msb};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_off = off;
        cur_msb = msb;
    endtask

    // fixed_len < 0: random frame, noise or broken sync
    task automatic send_frame(input int fixed_len);
        logic [7:0]  hdr [HDR_N];
        logic [7:0]  fsum, b;
        logic [15:0] len;
        int          pick, cut;
        pick = $urandom_range(0, 99);
        if (fixed_len < 0 && pick < 8) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            return;
        end
        if (fixed_len < 0 && pick < 18) begin
            cut = $urandom_range(1, 3);
            send_byte(SYNC_C);
            if (cut > 1) send_byte(SYNC_P);
            if (cut > 2) send_byte(SYNC_P);
            b = 8'($urandom);
            if (b == ((cut == 3) ? SYNC_NUL : SYNC_P))
                b = ~b;
            send_byte(b);
            return;
        end
        if (fixed_len >= 0) begin
            len = 16'(fixed_len);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                len = 16'd0;
            else if (pick < 80)
                len = 16'($urandom_range(1, 24));
            else if (pick < 82)
                len = 16'($urandom_range(25, int'(MAX_PAYLOAD)));
            else if (pick < 86)
                len = MAX_PAYLOAD + 16'd1;
            else
                len = 16'($urandom_range(int'(MAX_PAYLOAD) + 1, 65535));
        end
        // field starting on the last header byte: only its first half lands
        if (int'(cur_off) + 1 >= HDR_N)
            len &= cur_msb ? 16'hFF00 : 16'h00FF;
        foreach (hdr[i])
            hdr[i] = 8'($urandom);
        hdr[cur_off] = cur_msb ? len[15:8] : len[7:0];
        if (int'(cur_off) + 1 < HDR_N)
            hdr[int'(cur_off) + 1] = cur_msb ? len[7:0] : len[15:8];

        send_byte(SYNC_C);
        send_byte(SYNC_P);
        send_byte(SYNC_P);
        send_byte(SYNC_NUL);
        fsum = SYNC_C + SYNC_P + SYNC_P + SYNC_NUL;
        foreach (hdr[i]) begin
            send_byte(hdr[i]);
            fsum += hdr[i];
        end
        if (len > MAX_PAYLOAD)
            return;
        repeat (len) begin
            b = 8'($urandom);
            send_byte(b);
            fsum += b;
        end
        b = ($urandom_range(0, 3) != 0) ? 8'(8'd0 - fsum) : 8'($urandom);
        send_byte(b);
    endtask

    initial begin : stimulus
        logic [7:0] opening [11];
        logic [2:0] offs [6];
        logic       msbs [6];
        opening = '{8'h00, 8'hFF, SYNC_C, SYNC_C, SYNC_C, SYNC_P, SYNC_C,
                    SYNC_C, SYNC_P, SYNC_P, 8'h01};
        offs = '{3'd0, 3'd6, 3'd6, 3'd7, 3'd7, 3'd3};
        msbs = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // hunt extremes, mismatch at each sync byte, then an empty frame
        foreach (opening[i])
            send_byte(opening[i]);
        send_frame(0);

        for (int p = 0; p < PHASES; p++) begin
            if (p < 6)
                set_parser(offs[p], msbs[p]);
            else
                set_parser(3'($urandom_range(0, 7)), 1'($urandom));
            case ($urandom_range(0, 2))
                0: s_idle_pct = 0;
                1: s_idle_pct = 15;
                default: s_idle_pct = 40;
            endcase
            if (p == PHASES - 1)
                tail = 1'b1;
            if (p == 2) begin
                send_frame(int'(MAX_PAYLOAD));
                send_frame(int'(MAX_PAYLOAD) + 1);
            end
            while (sent_items < ITEM_TARGET * (p + 1) / PHASES)
                send_frame(-1);
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        #1;
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin : result_stall
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!tail && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 60)) @(posedge aclk);
        end
    end

    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck = 0;
            else
                stuck++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule
